// ----- rtl/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// sss_pkg: shared types and codes of the scoped symbol stack
// Beat layouts, command and status codes, and the cell chain control word.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Default sizing
  localparam int STACK_DEPTH_DEF = 256;
  localparam int KEY_CHARS_DEF   = 8;

  // Field widths fixed by the interface
  localparam int KEY_W    = 64;
  localparam int LINE_W   = 24;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ENTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECLARE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSCOPE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Cell chain operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_PUSH = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [LINE_W-1:0] line_num;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [LINE_W-1:0]   line_out;
  } out_beat_t;

  // One stack entry; key zero marks a scope boundary
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LINE_W-1:0] line;
  } entry_t;

  // Control word broadcast along the chain
  typedef struct packed {
    logic [1:0] op;
    entry_t     new_ent;
  } cell_ctl_t;

endpackage

// ----- rtl/sss_stream_if.sv -----
// ----------------------------------------------------------------------------
// sss_stream_if: valid/ready channel
// Carries one payload beat per handshake; source drives, sink accepts.
// ----------------------------------------------------------------------------
interface sss_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/sss_cell.sv -----
// ----------------------------------------------------------------------------
// sss_cell: one stack slot of the cell chain
// Holds one entry; shifts toward the bottom on push, toward the top on pop,
// and rotates inside the occupied region during a scan.
// ----------------------------------------------------------------------------
module sss_cell #(
  parameter int IDX   = 0,
  parameter int TOP_W = 9
) (
  input  logic               clk,
  input  sss_pkg::cell_ctl_t ctl,
  input  logic [TOP_W-1:0]   top_cnt,
  input  sss_pkg::entry_t    prev_ent,   // toward the top of stack
  input  sss_pkg::entry_t    next_ent,   // toward the bottom of stack
  input  sss_pkg::entry_t    head_ent,   // cell 0, wraps in on rotate
  output sss_pkg::entry_t    ent_q
);
  import sss_pkg::*;

  // This cell is the last occupied one when IDX+1 == top
  localparam logic [TOP_W-1:0] SelC = TOP_W'(IDX + 1);

  entry_t ent_r;
  entry_t ent_nxt;

  // Next entry by chain operation
  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.op)
      OP_PUSH: ent_nxt = prev_ent;
      OP_POP:  ent_nxt = next_ent;
      OP_ROT: begin
        if (SelC == top_cnt) begin
          ent_nxt = head_ent;
        end else if (SelC < top_cnt) begin
          ent_nxt = next_ent;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent_q = ent_r;

endmodule

// ----- rtl/sss_ctrl.sv -----
// ----------------------------------------------------------------------------
// sss_ctrl: command sequencer of the scoped symbol stack
// Takes command beats, drives the cell chain, compares the head cell
// during scans and pops, and holds the result in the output register.
// ----------------------------------------------------------------------------
module sss_ctrl #(
  parameter int STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF,
  parameter int KEY_CHARS   = sss_pkg::KEY_CHARS_DEF,
  parameter int TOP_W       = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  sss_stream_if.sink         in_bus,
  sss_stream_if.source       out_bus,
  input  sss_pkg::entry_t    head_ent,
  output sss_pkg::cell_ctl_t ctl,
  output logic [TOP_W-1:0]   top_cnt
);
  import sss_pkg::*;

  localparam int KeyBits = KEY_CHARS * 8;
  localparam logic [KEY_W-1:0] KeyMask =
    (KeyBits >= KEY_W) ? {KEY_W{1'b1}} : ((64'd1 << KeyBits) - 64'd1);
  localparam logic [TOP_W-1:0] FullC = TOP_W'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [TOP_W-1:0]  top_r, top_nxt;
  logic [TOP_W-1:0]  cnt_r, cnt_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              hit_r, hit_nxt;     // scan decision made
  logic              dup_r, dup_nxt;
  logic              found_r, found_nxt;
  logic [LINE_W-1:0] fline_r, fline_nxt;
  out_beat_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;
  logic [1:0]        op;
  entry_t            new_ent;
  logic [KEY_W-1:0]  in_key;
  logic              in_fire;

  assign in_key  = in_bus.data.key & KeyMask;
  assign in_fire = in_bus.valid && in_bus.ready;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    line_nxt      = line_r;
    hit_nxt       = hit_r;
    dup_nxt       = dup_r;
    found_nxt     = found_r;
    fline_nxt     = fline_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    op            = OP_HOLD;
    new_ent.key   = key_r;
    new_ent.line  = line_r;

    if (out_bus.valid && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_bus.data.cmd;
          key_nxt   = in_key;
          line_nxt  = in_bus.data.line_num;
          cnt_nxt   = top_r;
          hit_nxt   = 1'b0;
          dup_nxt   = 1'b0;
          found_nxt = 1'b0;
          fline_nxt = '0;
          res_nxt   = '0;
          case (in_bus.data.cmd)
            CMD_ENTER: begin
              // push a boundary entry
              if (top_r == FullC) begin
                res_nxt.status = ST_FULL;
              end else begin
                op           = OP_PUSH;
                new_ent.key  = '0;
                new_ent.line = '0;
                top_nxt      = top_r + TOP_W'(1);
              end
              state_nxt = S_DONE;
            end
            CMD_EXIT: begin
              state_nxt = S_EXIT;
            end
            default: begin
              if (in_key == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cnt_r == '0) begin
          // whole occupied region has passed the head; order restored
          if (cmd_r == CMD_DECLARE) begin
            if (dup_r) begin
              res_nxt.status = ST_DUP;
            end else if (top_r == FullC) begin
              res_nxt.status = ST_FULL;
            end else begin
              op      = OP_PUSH;
              top_nxt = top_r + TOP_W'(1);
            end
          end else begin
            res_nxt.found    = found_r;
            res_nxt.line_out = fline_r;
          end
          state_nxt = S_DONE;
        end else begin
          op      = OP_ROT;
          cnt_nxt = cnt_r - TOP_W'(1);
          // head visits entries newest first
          if (!hit_r) begin
            if (cmd_r == CMD_DECLARE) begin
              if (head_ent.key == '0) begin
                hit_nxt = 1'b1;
              end else if (head_ent.key == key_r) begin
                hit_nxt = 1'b1;
                dup_nxt = 1'b1;
              end
            end else if (head_ent.key == key_r) begin
              hit_nxt   = 1'b1;
              found_nxt = 1'b1;
              fline_nxt = head_ent.line;
            end
          end
        end
      end

      S_EXIT: begin
        // pop one entry a cycle through the latest boundary, or until the stack is empty
        if (top_r == '0) begin
          res_nxt.status = ST_NOSCOPE;
          state_nxt      = S_DONE;
        end else begin
          op      = OP_POP;
          top_nxt = top_r - TOP_W'(1);
          if (head_ent.key == '0) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    line_r     <= line_nxt;
    hit_r      <= hit_nxt;
    dup_r      <= dup_nxt;
    found_r    <= found_nxt;
    fline_r    <= fline_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_bus.ready  = (state_r == S_IDLE);
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;
  assign ctl.op        = op;
  assign ctl.new_ent   = new_ent;
  assign top_cnt       = top_r;

  // Checks
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_PUSH) |-> (top_r < FullC))
    else $error("push on full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_POP) |-> (top_r != '0))
    else $error("pop on empty stack");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_PUSH) |=> (top_r == $past(top_r) + TOP_W'(1)))
    else $error("push did not grow the stack by one");

  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_ROT) |=> $stable(top_r))
    else $error("rotate changed the stack count");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result shown outside completion");

endmodule

// ----- rtl/scoped_symbol_stack_unit.sv -----
// From accept to result valid: enter, and declare or find with an empty key, go straight to the done state;
// declare and find first rotate all top entries past the head cell, top being the number of stack entries;
// exit pops entries through the latest boundary, or until the stack is empty and then reports no scope.
// Scans rotate the occupied cells past the head cell and exit pops, one entry per cycle.
// One item at a time: the next beat is taken once the result is in the output register.
// Reset clears the sequencer and the entry count; cell contents stay undefined.
// ----------------------------------------------------------------------------
// scoped_symbol_stack_unit: scoped symbol table in a chain of stack cells
// Enter, exit, declare and find commands over a stack of (key, line)
// entries, with boundaries marked by key zero.
// ----------------------------------------------------------------------------
module scoped_symbol_stack_unit #(
  parameter int STACK_DEPTH = sss_pkg::STACK_DEPTH_DEF,
  parameter int KEY_CHARS   = sss_pkg::KEY_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sss_stream_if.sink   in_bus,
  sss_stream_if.source out_bus
);
  import sss_pkg::*;

  localparam int TopW = $clog2(STACK_DEPTH + 1);

  cell_ctl_t        ctl;
  logic [TopW-1:0]  top_cnt;
  entry_t           cell_q [STACK_DEPTH];

  // Sequencer
  sss_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .KEY_CHARS   (KEY_CHARS),
    .TOP_W       (TopW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .head_ent (cell_q[0]),
    .ctl      (ctl),
    .top_cnt  (top_cnt)
  );

  // Cell chain; cell 0 holds the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;

    if (i == 0) begin : g_first
      assign prev_ent = ctl.new_ent;
    end else begin : g_mid_prev
      assign prev_ent = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_ent = cell_q[i];
    end else begin : g_mid_next
      assign next_ent = cell_q[i+1];
    end

    sss_cell #(
      .IDX   (i),
      .TOP_W (TopW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .top_cnt  (top_cnt),
      .prev_ent (prev_ent),
      .next_ent (next_ent),
      .head_ent (cell_q[0]),
      .ent_q    (cell_q[i])
    );
  end

endmodule
